@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/s2dec_pkg.sv @@
// Constants for the signed integer to decimal text converter.
package s2dec_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned QUOT_SHIFT = 35;

  // Reciprocal of ten scaled by 2**35; exact quotient for every 32-bit value.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;

endpackage

@@ sv/signed_int_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII converter, one character per strobe.
//
// A value is taken when start is high and busy is low. The block splits the
// magnitude into decimal digits with one shared multiplier (reciprocal of
// ten), a multiply state and a remainder state per digit, then sends a
// minus sign if the value is negative and the digits most significant
// first, one character per cycle. Each character is on out_char_code for
// one cycle with out_valid high, and out_last marks the final one; the
// receiver cannot hold characters off. While busy is high the block
// splits the magnitude, then sends the sign if the value is negative,
// then the digits. The last character leaves in the first cycle with
// busy low, and a new value can be taken at the edge that ends that cycle.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii
  import s2dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [7:0]         out_char_code,
  output logic               out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t                   state_r;
  logic [VALUE_W-1:0]       mag_r;
  logic [2*VALUE_W-1:0]     prod_r;
  logic                     neg_r;
  logic [DIGIT_W-1:0]       ndig_r;
  logic [DIGIT_W-1:0]       idx_r;
  logic                     out_valid_r;
  logic [CHAR_W-1:0]        out_char_code_r;
  logic                     out_last_r;
  logic [DIGIT_W-1:0]       digit_mem [MAX_DIGITS];

  logic [VALUE_W-1:0]       quot;
  logic [VALUE_W-1:0]       quot_x10;
  logic [VALUE_W-1:0]       rem_full;
  logic [DIGIT_W-1:0]       rem_digit;
  logic                     split_done;
  logic                     char_ok;

  always_comb begin
    quot       = VALUE_W'(prod_r[2*VALUE_W-1:QUOT_SHIFT]);
    quot_x10   = (quot << 3) + (quot << 1);
    rem_full   = mag_r - quot_x10;
    rem_digit  = rem_full[DIGIT_W-1:0];
    split_done = (quot == '0) || (ndig_r == DIGIT_W'(MAX_DIGITS - 1));
    char_ok    = (out_char_code_r == ASCII_MINUS) ||
                 ((out_char_code_r >= ASCII_ZERO) && (out_char_code_r <= ASCII_NINE));
  end

  // Digit store, written while the magnitude is split.
  always_ff @(posedge clk) begin
    if (state_r == ST_REM) begin
      digit_mem[ndig_r] <= rem_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            neg_r   <= in_value[VALUE_W-1];
            mag_r   <= in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                           : VALUE_W'(in_value);
            ndig_r  <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
          state_r <= ST_REM;
        end
        ST_REM: begin
          mag_r  <= quot;
          ndig_r <= ndig_r + 1'b1;
          if (split_done) begin
            idx_r   <= ndig_r;
            state_r <= neg_r ? ST_SIGN : ST_EMIT;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_SIGN: begin
          out_valid_r     <= 1'b1;
          out_char_code_r <= ASCII_MINUS;
          out_last_r      <= 1'b0;
          state_r         <= ST_EMIT;
        end
        ST_EMIT: begin
          out_valid_r     <= 1'b1;
          out_char_code_r <= ASCII_ZERO + CHAR_W'(digit_mem[idx_r]);
          out_last_r      <= (idx_r == '0);
          if (idx_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_last      = out_last_r;

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted value did not raise busy")
  `ASSERT_NEXT(a_last_gap, clk, rst_n, out_valid && out_last, !out_valid, "character after last")
  `ASSERT_SAME(a_char_set, clk, rst_n, out_valid, char_ok, "character outside sign and digits")
  `ASSERT_SAME(a_digit_count, clk, rst_n, busy, ndig_r <= DIGIT_W'(MAX_DIGITS), "digit count overrun")
  `ASSERT_SAME(a_idle_quiet, clk, rst_n, !busy && !$past(busy), !out_valid, "character while idle")

endmodule
